// ----- src/mbis_pkg.sv -----
// Package for the streaming median block: item types, cell control and state codes.
// It depends on nothing; every module in src imports it.
package mbis_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int MEDIAN_WIDTH = SAMPLE_WIDTH + 1;
    localparam int COUNT_WIDTH  = 7;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    last;
    } t_in_item;

    typedef struct packed {
        logic signed [MEDIAN_WIDTH-1:0] median_x2;
        logic [COUNT_WIDTH-1:0]         count;
        logic                           overflow;
    } t_out_item;

    // Broadcast to every cell of the chain in each cycle.
    typedef struct packed {
        logic    ins;
        logic    shift;
        t_sample key;
    } t_cell_ctrl;

    typedef enum logic {
        S_LOAD,
        S_DRAIN
    } t_state;

endpackage

// ----- src/median_by_insertion_sort.sv -----
// Streaming median: each accepted item is inserted in order into a chain of MAX_SAMPLES cells
// while one is free, one item per cycle while loading. The item flagged last closes the set; the
// chain then shifts down to the middle with input stalled, and the result (twice the median, the
// count and a drop flag) waits in an output register.
module median_by_insertion_sort
    import mbis_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);

    t_state         r_state;
    t_state         n_state;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_shift;
    logic [CW-1:0]  n_count_ins;
    logic           r_drop;
    logic           r_out_valid;
    t_out_item      r_out;

    t_cell_ctrl     cell_ctrl;
    t_sample        cell_val [MAX_SAMPLES];
    logic           cell_gt  [MAX_SAMPLES];

    logic           in_acc;
    logic           full;
    logic           out_free;
    logic           done;
    logic signed [MEDIAN_WIDTH-1:0] median;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign full        = (r_count == CW'(MAX_SAMPLES));
    assign n_count_ins = full ? r_count : r_count + 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign done        = (r_state == S_DRAIN) && (r_shift == '0) && out_free;

    assign cell_ctrl.ins   = in_acc && !full;
    assign cell_ctrl.shift = (r_state == S_DRAIN) && (r_shift != '0);
    assign cell_ctrl.key   = i_in.sample;

    for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
        t_sample left_val;
        logic    left_gt;
        t_sample right_val;

        if (i == 0) begin : g_head
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end else begin : g_body
            assign left_val = cell_val[i-1];
            assign left_gt  = cell_gt[i-1];
        end

        if (i == MAX_SAMPLES - 1) begin : g_tail
            assign right_val = cell_val[i];
        end else begin : g_inner
            assign right_val = cell_val[i+1];
        end

        mbis_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl),
            .i_occ        (CW'(i) < r_count),
            .i_first_free (CW'(i) == r_count),
            .i_left_val   (left_val),
            .i_left_gt    (left_gt),
            .i_right_val  (right_val),
            .o_val        (cell_val[i]),
            .o_gt         (cell_gt[i])
        );
    end

    // After the drain the head cell holds the lower middle element and the next cell the upper.
    always_comb begin
        if (r_count[0]) begin
            median = {cell_val[0], 1'b0};
        end else begin
            median = {cell_val[0][SAMPLE_WIDTH-1], cell_val[0]}
                   + {cell_val[1][SAMPLE_WIDTH-1], cell_val[1]};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc && i_in.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (done) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state == S_DRAIN);
        o_out_valid = r_out_valid;
        o_out       = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_shift     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (done) begin
                r_count <= '0;
            end else if (cell_ctrl.ins) begin
                r_count <= n_count_ins;
            end

            if (done) begin
                r_drop <= 1'b0;
            end else if (in_acc && full) begin
                r_drop <= 1'b1;
            end

            if (in_acc && i_in.last) begin
                r_shift <= (n_count_ins - 1'b1) >> 1;
            end else if (cell_ctrl.shift) begin
                r_shift <= r_shift - 1'b1;
            end

            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out.median_x2 <= median;
            r_out.count     <= COUNT_WIDTH'(r_count);
            r_out.overflow  <= r_drop;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("sample count beyond the chain length");

    a_close_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last) |=> (r_state == S_DRAIN))
        else $error("closing item did not start the drain");

    a_shift_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_shift != '0) |-> (r_state == S_DRAIN))
        else $error("shift count pending outside the drain");

    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (o_out_valid && r_count == '0 && !r_drop))
        else $error("result not presented or set not cleared after drain");

endmodule

// ----- src/mbis_cell.sv -----
// One cell of the sorted chain: holds a single sample and trades it with its neighbours.
// Depends on mbis_pkg for the sample and control types.
module mbis_cell
    import mbis_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occ,
    input  logic       i_first_free,
    input  t_sample    i_left_val,
    input  logic       i_left_gt,
    input  t_sample    i_right_val,
    output t_sample    o_val,
    output logic       o_gt
);

    t_sample r_val;
    t_sample n_val;

    // Strictly greater, so a new sample lands after any equal ones.
    assign o_gt  = i_occ && (r_val > i_ctrl.key);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins && (o_gt || i_first_free)) begin
            // Either the left neighbour moves up into this place, or the new item lands here.
            n_val = i_left_gt ? i_left_val : i_ctrl.key;
        end else if (i_ctrl.shift) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
